FILE: rtl/cnms_pkg.sv
package cnms_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int COORD_BITS  = 16;
    localparam int NUM_CLASSES = 80;
    localparam int SCORE_BITS  = 16;
    localparam int CLASS_BITS  = 7;
    localparam int AREA_BITS   = 2 * COORD_BITS;
    localparam int UNION_BITS  = AREA_BITS + 1;
    localparam int PROD_BITS   = UNION_BITS + SCORE_BITS;
    localparam logic [SCORE_BITS-1:0] THR_RESET = 16'd16384;
    localparam logic [2:0] EVAL_LAST = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] bottom;
        logic [SCORE_BITS-1:0]        score;
        logic [CLASS_BITS-1:0]        cls;
    } box_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic insert;
        logic shift;
        logic apply;
    } cell_ctrl_t;

    // positive extent of an interval, zero when empty or inverted
    function automatic logic [COORD_BITS-1:0] span(
        input logic signed [COORD_BITS-1:0] lo,
        input logic signed [COORD_BITS-1:0] hi
    );
        logic signed [COORD_BITS:0] d;
        d = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
        if (d <= 0)
            return '0;
        return d[COORD_BITS-1:0];
    endfunction

endpackage

FILE: rtl/cnms_cell.sv
module cnms_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cnms_pkg::cell_ctrl_t          ctrl,
    input  cnms_pkg::box_t                new_box,
    input  cnms_pkg::box_t                prev_box,
    input  logic                          prev_vld,
    input  logic                          prev_ge,
    input  cnms_pkg::box_t                next_box,
    input  logic                          next_vld,
    input  logic                          next_sup,
    input  cnms_pkg::box_t                bc_box,
    input  logic [cnms_pkg::AREA_BITS-1:0] bc_area,
    input  logic [cnms_pkg::SCORE_BITS-1:0] thr,
    output cnms_pkg::box_t                box,
    output logic                          vld,
    output logic                          sup,
    output logic                          ge
);
    import cnms_pkg::*;

    box_t box_reg, box_next;
    logic vld_reg, vld_next, sup_reg, sup_next;
    logic [COORD_BITS-1:0] iw_reg, ih_reg, ow_reg, oh_reg;
    logic [AREA_BITS-1:0]  inter2_reg, own2_reg, inter3_reg, inter4_reg;
    logic [UNION_BITS-1:0] uni_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  hit;

    assign box = box_reg;
    assign vld = vld_reg;
    assign sup = sup_reg;
    assign ge  = vld_reg && (box_reg.score >= new_box.score);

    // overlap test against the broadcast box
    assign hit = vld_reg && (box_reg.cls == bc_box.cls) &&
                 ({inter4_reg, {SCORE_BITS{1'b0}}} > prod_reg);

    // insertion, shift-out and suppression
    always_comb
    begin
        box_next = box_reg;
        vld_next = vld_reg;
        sup_next = sup_reg;
        if (ctrl.insert && !ge)
        begin
            vld_next = prev_ge ? 1'b1 : prev_vld;
            sup_next = 1'b0;
            box_next = prev_ge ? new_box : prev_box;
        end
        else if (ctrl.shift)
        begin
            box_next = next_box;
            vld_next = next_vld;
            sup_next = next_sup;
        end
        else if (ctrl.apply)
        begin
            sup_next = sup_reg | hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            sup_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            sup_reg <= sup_next;
        end
    end

    // overlap pipeline, payload only
    always_ff @(posedge clk)
    begin
        box_reg    <= box_next;
        iw_reg     <= span(box_reg.left > bc_box.left ? box_reg.left : bc_box.left,
                           box_reg.right < bc_box.right ? box_reg.right : bc_box.right);
        ih_reg     <= span(box_reg.top > bc_box.top ? box_reg.top : bc_box.top,
                           box_reg.bottom < bc_box.bottom ? box_reg.bottom : bc_box.bottom);
        ow_reg     <= span(box_reg.left, box_reg.right);
        oh_reg     <= span(box_reg.top, box_reg.bottom);
        inter2_reg <= AREA_BITS'(iw_reg * ih_reg);
        own2_reg   <= AREA_BITS'(ow_reg * oh_reg);
        uni_reg    <= UNION_BITS'({1'b0, own2_reg} + {1'b0, bc_area} - {1'b0, inter2_reg});
        inter3_reg <= inter2_reg;
        prod_reg   <= {{(PROD_BITS-SCORE_BITS){1'b0}}, thr} *
                      {{SCORE_BITS{1'b0}}, uni_reg};
        inter4_reg <= inter3_reg;
    end

endmodule

FILE: rtl/class_aware_nms.sv
// channel   direction  signals
// in        request    in_valid/in_ready, left top right bottom confidence class_id final_box
// out       result     out_valid/out_ready, kept_* overflowed last_kept
// cfg       write      cfg_valid/cfg_ready, cfg_data (iou_threshold)
//
// boxes load at one per cycle, while in_ready is high, into a score-ordered chain of cells
// after the final box a suppressed box at the head is shifted out, and a kept box passes
// through the head, the overlap pipeline and the hand-over of the previous kept box,
// the hand-over waiting on out while it stalls
// reset clears the chain and sets the threshold to 0.25; out stalls hold the sequencer
module class_aware_nms (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [cnms_pkg::COORD_BITS-1:0]  left,
    input  logic signed [cnms_pkg::COORD_BITS-1:0]  top,
    input  logic signed [cnms_pkg::COORD_BITS-1:0]  right,
    input  logic signed [cnms_pkg::COORD_BITS-1:0]  bottom,
    input  logic [cnms_pkg::SCORE_BITS-1:0]         confidence,
    input  logic [cnms_pkg::CLASS_BITS-1:0]         class_id,
    input  logic                                    final_box,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cnms_pkg::COORD_BITS-1:0]  kept_left,
    output logic signed [cnms_pkg::COORD_BITS-1:0]  kept_top,
    output logic signed [cnms_pkg::COORD_BITS-1:0]  kept_right,
    output logic signed [cnms_pkg::COORD_BITS-1:0]  kept_bottom,
    output logic [cnms_pkg::SCORE_BITS-1:0]         kept_confidence,
    output logic [cnms_pkg::CLASS_BITS-1:0]         kept_class,
    output logic                                    overflowed,
    output logic                                    last_kept,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [cnms_pkg::SCORE_BITS-1:0]         cfg_data
);
    import cnms_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_HEAD = 5'b00010,
        S_EVAL = 5'b00100,
        S_REL  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [SCORE_BITS-1:0] thr_reg;
    logic [$clog2(MAX_BOXES+1)-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next, pend_reg, pend_next, outv_reg, outv_next, last_reg, last_next;
    logic [2:0] cnt_reg, cnt_next;
    box_t bc_reg, bc_next, pend_box_reg, pend_box_next, in_box;
    logic [COORD_BITS-1:0] bw_reg, bh_reg;
    logic [AREA_BITS-1:0]  barea_reg;
    cell_ctrl_t ctrl;
    logic in_fire, out_fire;

    box_t cbox [MAX_BOXES];
    logic cvld [MAX_BOXES];
    logic csup [MAX_BOXES];
    logic cge  [MAX_BOXES];

    assign in_box    = '{left: left, top: top, right: right, bottom: bottom,
                         score: confidence, cls: class_id};
    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = outv_reg && out_ready;
    assign cfg_ready = 1'b1;

    assign out_valid       = outv_reg;
    assign kept_left       = pend_box_reg.left;
    assign kept_top        = pend_box_reg.top;
    assign kept_right      = pend_box_reg.right;
    assign kept_bottom     = pend_box_reg.bottom;
    assign kept_confidence = pend_box_reg.score;
    assign kept_class      = pend_box_reg.cls;
    assign overflowed      = ovf_reg;
    assign last_kept       = last_reg;

    // chain of cells
    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        cnms_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .new_box  (in_box),
            .prev_box (i == 0 ? in_box : cbox[(i == 0) ? 0 : i-1]),
            .prev_vld (i == 0 ? 1'b1 : cvld[(i == 0) ? 0 : i-1]),
            .prev_ge  (i == 0 ? 1'b1 : cge[(i == 0) ? 0 : i-1]),
            .next_box (i == MAX_BOXES-1 ? in_box : cbox[(i == MAX_BOXES-1) ? i : i+1]),
            .next_vld (i == MAX_BOXES-1 ? 1'b0 : cvld[(i == MAX_BOXES-1) ? i : i+1]),
            .next_sup (i == MAX_BOXES-1 ? 1'b0 : csup[(i == MAX_BOXES-1) ? i : i+1]),
            .bc_box   (bc_reg),
            .bc_area  (barea_reg),
            .thr      (thr_reg),
            .box      (cbox[i]),
            .vld      (cvld[i]),
            .sup      (csup[i]),
            .ge       (cge[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pend_next     = pend_reg;
        outv_next     = outv_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        bc_next       = bc_reg;
        pend_box_next = pend_box_reg;
        ctrl          = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg == ($clog2(MAX_BOXES+1))'(MAX_BOXES))
                        ovf_next = 1'b1;
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    if (final_box)
                        state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (!cvld[0])
                begin
                    count_next = '0;
                    if (pend_reg)
                    begin
                        outv_next  = 1'b1;
                        last_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                end
                else if (csup[0])
                    ctrl.shift = 1'b1;
                else
                begin
                    bc_next    = cbox[0];
                    cnt_next   = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == EVAL_LAST)
                begin
                    ctrl.apply = 1'b1;
                    state_next = S_REL;
                    if (pend_reg)
                    begin
                        outv_next = 1'b1;
                        last_next = 1'b0;
                    end
                end
            end
            // hand over the previous kept box, then retire the head
            S_REL:
            begin
                if (out_fire || !outv_reg)
                begin
                    outv_next     = 1'b0;
                    pend_next     = 1'b1;
                    pend_box_next = bc_reg;
                    ctrl.shift    = 1'b1;
                    state_next    = S_HEAD;
                end
            end
            S_DONE:
            begin
                if (out_fire)
                begin
                    outv_next  = 1'b0;
                    pend_next  = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            outv_reg  <= 1'b0;
            last_reg  <= 1'b0;
            cnt_reg   <= '0;
            thr_reg   <= THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            outv_reg  <= outv_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
        end
    end

    // broadcast box and its area
    always_ff @(posedge clk)
    begin
        bc_reg       <= bc_next;
        pend_box_reg <= pend_box_next;
        bw_reg       <= span(bc_reg.left, bc_reg.right);
        bh_reg       <= span(bc_reg.top, bc_reg.bottom);
        barea_reg    <= AREA_BITS'(bw_reg * bh_reg);
    end

endmodule

FILE: sim/nms_checker.sv
module nms_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] left,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] top,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] right,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] bottom,
    input  logic [cnms_pkg::SCORE_BITS-1:0]        confidence,
    input  logic [cnms_pkg::CLASS_BITS-1:0]        class_id,
    input  logic                                   final_box,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] kept_left,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] kept_top,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] kept_right,
    input  logic signed [cnms_pkg::COORD_BITS-1:0] kept_bottom,
    input  logic [cnms_pkg::SCORE_BITS-1:0]        kept_confidence,
    input  logic [cnms_pkg::CLASS_BITS-1:0]        kept_class,
    input  logic                                   overflowed,
    input  logic                                   last_kept,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [cnms_pkg::SCORE_BITS-1:0]        cfg_data,
    output int                                     errors,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cnms_pkg::*;

    typedef struct {
        box_t b;
        bit   ovf;
        bit   last;
    } kept_box_t;

    box_t            frame_boxes[MAX_BOXES];
    int              frame_count;
    bit              frame_ovf;
    logic [15:0]     iou_thr;
    kept_box_t       kept_fifo[$];

    function automatic longint box_area(box_t b);
        longint w;
        longint h;
        w = longint'($signed(b.right)) - longint'($signed(b.left));
        h = longint'($signed(b.bottom)) - longint'($signed(b.top));
        if (w <= 0 || h <= 0)
            return 0;
        return w * h;
    endfunction

    function automatic longint overlap_area(box_t a, box_t b);
        longint l;
        longint r;
        longint t;
        longint bt;
        l  = $signed(a.left) > $signed(b.left) ? $signed(a.left) : $signed(b.left);
        r  = $signed(a.right) < $signed(b.right) ? $signed(a.right) : $signed(b.right);
        t  = $signed(a.top) > $signed(b.top) ? $signed(a.top) : $signed(b.top);
        bt = $signed(a.bottom) < $signed(b.bottom) ? $signed(a.bottom) : $signed(b.bottom);
        if (r - l <= 0 || bt - t <= 0)
            return 0;
        return (r - l) * (bt - t);
    endfunction

    // sort by score, greedy suppression per class, queue the survivors
    task automatic suppress_frame();
        int  order[MAX_BOXES];
        bit  kept[MAX_BOXES];
        int  i;
        int  j;
        int  cur;
        int  nk;
        int  done;
        bit  keep;
        longint inter;
        longint uni;
        kept_box_t k;
        for (i = 0; i < frame_count; i++)
        begin
            j = i;
            while (j > 0 && frame_boxes[order[j-1]].score < frame_boxes[i].score)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            kept[i] = 0;
        end
        nk = 0;
        for (i = 0; i < frame_count; i++)
        begin
            cur = order[i];
            keep = 1;
            for (j = 0; j < i && keep; j++)
            begin
                if (kept[order[j]] && frame_boxes[order[j]].cls == frame_boxes[cur].cls)
                begin
                    inter = overlap_area(frame_boxes[cur], frame_boxes[order[j]]);
                    uni = box_area(frame_boxes[cur]) + box_area(frame_boxes[order[j]]) - inter;
                    if (inter * 65536 > longint'(iou_thr) * uni)
                        keep = 0;
                end
            end
            if (keep)
            begin
                kept[cur] = 1;
                nk++;
            end
        end
        done = 0;
        for (i = 0; i < frame_count; i++)
        begin
            if (kept[order[i]])
            begin
                done++;
                k.b = frame_boxes[order[i]];
                k.ovf = frame_ovf;
                k.last = (done == nk);
                kept_fifo = {kept_fifo, k};
            end
        end
        frame_count = 0;
        frame_ovf = 0;
    endtask

    task automatic report(string what, longint exp_v, longint act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, what, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kept_box_t e;
        box_t nb;
        if (!rst_n)
        begin
            frame_count = 0;
            frame_ovf = 0;
            iou_thr = THR_RESET;
            errors = 0;
            pending = kept_fifo.size();
        end
        else
        begin
            // threshold write
            if (cfg_valid && cfg_ready)
                iou_thr = cfg_data;
            // incoming request
            if (in_valid && in_ready)
            begin
                nb.left = left;
                nb.top = top;
                nb.right = right;
                nb.bottom = bottom;
                nb.score = confidence;
                nb.cls = class_id;
                if (frame_count < MAX_BOXES)
                begin
                    frame_boxes[frame_count] = nb;
                    frame_count++;
                end
                else
                    frame_ovf = 1;
                if (final_box)
                    suppress_frame();
            end
            // result compare
            if (out_valid && out_ready)
            begin
                if (kept_fifo.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual score %0d",
                             $realtime, kept_confidence);
                end
                else
                begin
                    e = kept_fifo.pop_front();
                    if (kept_left !== e.b.left)
                        report("kept_left", $signed(e.b.left), $signed(kept_left));
                    if (kept_top !== e.b.top)
                        report("kept_top", $signed(e.b.top), $signed(kept_top));
                    if (kept_right !== e.b.right)
                        report("kept_right", $signed(e.b.right), $signed(kept_right));
                    if (kept_bottom !== e.b.bottom)
                        report("kept_bottom", $signed(e.b.bottom), $signed(kept_bottom));
                    if (kept_confidence !== e.b.score)
                        report("kept_confidence", e.b.score, kept_confidence);
                    if (kept_class !== e.b.cls)
                        report("kept_class", e.b.cls, kept_class);
                    if (overflowed !== e.ovf)
                        report("overflowed", e.ovf, overflowed);
                    if (last_kept !== e.last)
                        report("last_kept", e.last, last_kept);
                end
            end
            pending = kept_fifo.size();
        end
    end

endmodule

FILE: sim/class_aware_nms_tb.sv
module class_aware_nms_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cnms_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
    logic [SCORE_BITS-1:0]        confidence;
    logic [CLASS_BITS-1:0]        class_id;
    logic                         final_box;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [COORD_BITS-1:0] kept_left;
    logic signed [COORD_BITS-1:0] kept_top;
    logic signed [COORD_BITS-1:0] kept_right;
    logic signed [COORD_BITS-1:0] kept_bottom;
    logic [SCORE_BITS-1:0]        kept_confidence;
    logic [CLASS_BITS-1:0]        kept_class;
    logic                         overflowed;
    logic                         last_kept;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [SCORE_BITS-1:0]        cfg_data;

    int errors;
    int pending;
    int idle_cycles;
    int sent;
    bit hold_req;
    bit hold_done;

    class_aware_nms i_dut (.*);

    nms_checker i_checker (.*);

    initial clk = 0;
    always #4 clk = ~clk;

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one box request, random gap before it
    task automatic send_box(box_t b, bit fin);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        left = b.left;
        top = b.top;
        right = b.right;
        bottom = b.bottom;
        confidence = b.score;
        class_id = b.cls;
        final_box = fin;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    function automatic box_t make_box(int x, int y, int w, int h, int sc, int c);
        box_t b;
        b.left = 16'(x);
        b.top = 16'(y);
        b.right = 16'(x + w);
        b.bottom = 16'(y + h);
        b.score = 16'(sc);
        b.cls = 7'(c);
        return b;
    endfunction

    // boxes clustered so that same-class overlaps are common
    function automatic box_t rand_box();
        box_t b;
        if ($urandom_range(0, 4) == 0)
        begin
            b.left = 16'($urandom);
            b.top = 16'($urandom);
            b.right = 16'($urandom);
            b.bottom = 16'($urandom);
            b.score = 16'($urandom);
            b.cls = 7'($urandom);
        end
        else
        begin
            b = make_box($urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                         $urandom_range(0, 50), $urandom_range(0, 50),
                         $urandom_range(0, 15) * 4096 + $urandom_range(0, 1),
                         $urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                b.cls = 7'($urandom);
        end
        return b;
    endfunction

    task automatic send_frame(int n);
        for (int i = 0; i < n; i++)
            send_box(rand_box(), i == n - 1);
    endtask

    // threshold write once everything has drained
    task automatic write_threshold(logic [15:0] thr);
        in_valid = 0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data = thr;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin
        int stall;
        out_ready = 0;
        hold_done = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1;
            end
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready = 0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        box_t big;
        in_valid = 0;
        left = 0;
        top = 0;
        right = 0;
        bottom = 0;
        confidence = 0;
        class_id = 0;
        final_box = 0;
        cfg_valid = 0;
        cfg_data = 0;
        hold_req = 0;
        sent = 0;
        idle_cycles = 0;
        rst_n = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // extremes, equal scores, inverted, touching and zero-area boxes
        big.left = 16'h8000;
        big.top = 16'h8000;
        big.right = 16'h7fff;
        big.bottom = 16'h7fff;
        big.score = 16'hffff;
        big.cls = 7'h7f;
        send_box(big, 0);
        send_box(big, 0);
        send_box(make_box(10, 10, -5, 20, 0, 127), 0);
        send_box(make_box(0, 0, 10, 10, 30000, 5), 0);
        send_box(make_box(10, 0, 10, 10, 30000, 5), 0);
        send_box(make_box(0, 0, 0, 0, 20000, 5), 0);
        send_box(make_box(0, 0, 0, 0, 20000, 5), 0);
        send_box(make_box(2, 0, 10, 10, 40000, 5), 0);
        send_box(make_box(-20, -20, 10, 10, 1, 100), 1);
        send_box(make_box(0, 0, 0, 0, 0, 0), 1);

        // threshold at zero: any overlap suppresses
        write_threshold(16'h0000);
        send_box(make_box(0, 0, 10, 10, 500, 1), 0);
        send_box(make_box(9, 9, 10, 10, 400, 1), 0);
        send_box(make_box(9, 9, 10, 10, 400, 2), 1);

        // threshold at the top: identical boxes still suppress, near-identical ones survive
        write_threshold(16'hffff);
        send_box(make_box(0, 0, 10, 10, 500, 1), 0);
        send_box(make_box(0, 0, 10, 10, 500, 1), 0);
        send_box(make_box(1, 0, 10, 10, 600, 1), 1);

        // long output hold while a frame beyond capacity arrives
        write_threshold(THR_RESET);
        hold_req = 1;
        send_frame(3);
        send_frame(MAX_BOXES + 2);
        send_frame(2);

        // random frames, mostly small, threshold changed now and then
        while (sent < 110)
        begin
            if ($urandom_range(0, 3) == 0)
                write_threshold(16'($urandom));
            send_frame($urandom_range(1, 8));
        end

        in_valid = 0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
